FILE: hw/rtl/dgv_pkg.sv
// Shared types, constants and helpers for the drag/gravity velocity step block.
`default_nettype none
package dgv_pkg;

	// CORDIC depth and arctangent table (32-bit binary angle, pi/4 first)
	localparam int ANGLE_ITERATIONS = 16;
	localparam int CORDIC_TABLE_LEN = 24;
	localparam logic [31:0] ATAN_TAB [CORDIC_TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// pipeline depths
	localparam int FRONT_STAGES = 6;
	localparam int SQRT_STEPS   = 32;
	localparam int CORDIC_LAT   = ANGLE_ITERATIONS + 1;
	localparam int PIPE_LAT     = FRONT_STAGES + SQRT_STEPS + CORDIC_LAT + 1;

	// register file
	localparam logic [23:0] DRAG_RESET    = 24'd10066;
	localparam logic [21:0] GRAVITY_RESET = 22'd642409;
	typedef enum logic {
		REG_DRAG    = 1'b0,
		REG_GRAVITY = 1'b1
	} reg_idx_t;

	// values carried alongside the magnitude and angle units
	typedef struct packed {
		logic [31:0] nv_n;
		logic [31:0] nv_e;
		logic [31:0] nv_d;
		logic [31:0] ac_n;
		logic [31:0] ac_e;
		logic [31:0] ac_d;
	} side_t;

	typedef struct packed {
		side_t       side;
		logic [31:0] total;
		logic [31:0] ground;
	} spd_t;

	// clamp a 36-bit signed value to the 32-bit signed range
	function automatic logic [31:0] sat32(input logic signed [35:0] x);
		logic [31:0] r;
		if (x > 36'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (x < -36'sd2147483648)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	// magnitude of a 32-bit signed value, as unsigned
	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dgv_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
`default_nettype none
module dgv_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] radicand,
	output logic [31:0]      root
);
	import dgv_pkg::*;

	logic [63:0] bits_s [SQRT_STEPS];
	logic [35:0] rem_s  [SQRT_STEPS];
	logic [31:0] root_s [SQRT_STEPS+1];

	assign bits_s[0] = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	// restoring square root: bring down two bits, try (4*root+1)
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;
		assign cur   = {rem_s[i][33:0], bits_s[i][63:62]};
		assign trial = {2'b00, root_s[i], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[i+1] <= {root_s[i][30:0], ge};
			end
		end

		if (i < SQRT_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1]  <= ge ? (cur - trial) : cur;
					bits_s[i+1] <= {bits_s[i][61:0], 2'b00};
				end
			end
		end
	end

	assign root = root_s[SQRT_STEPS];

endmodule
`default_nettype wire

FILE: hw/rtl/dgv_cordic.sv
// Pipelined vectoring CORDIC giving a 16-bit binary angle of (x, y).
`default_nettype none
module dgv_cordic (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [32:0] x_in,
	input  wire logic signed [32:0] y_in,
	output logic [15:0]             angle
);
	import dgv_pkg::*;

	logic signed [35:0] x_s [ANGLE_ITERATIONS+1];
	logic signed [35:0] y_s [ANGLE_ITERATIONS+1];
	logic signed [33:0] z_s [ANGLE_ITERATIONS+1];
	logic               zero_s [ANGLE_ITERATIONS+1];

	logic signed [35:0] xw;
	logic signed [35:0] yw;
	logic signed [33:0] zr;

	assign xw = 36'(x_in);
	assign yw = 36'(y_in);

	// quadrant fold into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (xw < 0) begin
				if (yw >= 0) begin
					x_s[0] <= yw;
					y_s[0] <= -xw;
					z_s[0] <= 34'sh040000000;
				end else begin
					x_s[0] <= -yw;
					y_s[0] <= xw;
					z_s[0] <= -34'sh040000000;
				end
			end else begin
				x_s[0] <= xw;
				y_s[0] <= yw;
				z_s[0] <= '0;
			end
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
		logic signed [35:0] dx;
		logic signed [35:0] dy;
		logic signed [33:0] at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = $signed({2'b00, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	// round to 16 bits, halves up; wraps
	assign zr    = z_s[ANGLE_ITERATIONS] + 34'sh000008000;
	assign angle = zero_s[ANGLE_ITERATIONS] ? 16'h0000 : zr[31:16];

endmodule
`default_nettype wire

FILE: hw/rtl/drag_gravity_velocity_step.sv
// Top level: linear drag and gravity Euler step with speeds and angles.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+-----------------------------
//   item      | in        | item_valid / item_stall    | vel_north/east/down, time_step
//   result    | out       | result_valid / result_stall| next_*, accel_*, speeds, angles
//   config    | in        | APB psel/penable/pwrite    | drag_coefficient, gravity_accel
//
// One beat enters per cycle unless the result stalls. Stages: 6 arithmetic,
// 32 square root, ANGLE_ITERATIONS+1 CORDIC, then one output register.
// A stalled result freezes the whole pipeline, so item_stall follows it.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none
module drag_gravity_velocity_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic signed [31:0] vel_north,
	input  wire logic signed [31:0] vel_east,
	input  wire logic signed [31:0] vel_down,
	input  wire logic [15:0]        time_step,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      next_north,
	output logic signed [31:0]      next_east,
	output logic signed [31:0]      next_down,
	output logic signed [31:0]      accel_north,
	output logic signed [31:0]      accel_east,
	output logic signed [31:0]      accel_down,
	output logic [31:0]             total_speed,
	output logic [31:0]             ground_speed,
	output logic signed [15:0]      pitch_angle,
	output logic signed [15:0]      heading_angle,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import dgv_pkg::*;

	logic        en;
	logic [23:0] drag_q;
	logic [21:0] grav_q;
	logic [PIPE_LAT-1:0] vld_q;
	reg_idx_t    sel;

	// global advance: hold everything while a result waits
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;
	assign result_valid = vld_q[PIPE_LAT-1];

	// config registers
	assign sel    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q <= DRAG_RESET;
			grav_q <= GRAVITY_RESET;
		end else if (psel && penable && pwrite) begin
			case (sel)
				REG_DRAG:    drag_q <= pwdata[23:0];
				REG_GRAVITY: grav_q <= pwdata[21:0];
				default:     drag_q <= drag_q;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_DRAG:    prdata = {8'h00, drag_q};
			REG_GRAVITY: prdata = {10'h000, grav_q};
			default:     prdata = '0;
		endcase
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], item_valid};
		end
	end

	logic [31:0] vin [3];
	assign vin[0] = vel_north;
	assign vin[1] = vel_east;
	assign vin[2] = vel_down;

	// stage 1: |v| * drag
	logic [55:0] dprod_s1 [3];
	logic [31:0] vel_s1 [3];
	logic [15:0] dt_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dprod_s1[k] <= 56'(mag32(vin[k])) * 56'(drag_q);
				vel_s1[k]   <= vin[k];
			end
			dt_s1 <= time_step;
		end
	end

	// stage 2: round, oppose velocity, add gravity, saturate
	logic [31:0] acc_s2 [3];
	logic [31:0] vel_s2 [3];
	logic [15:0] dt_s2;
	always_ff @(posedge clk) begin
		logic [56:0]        rs;
		logic signed [35:0] a0;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rs = {1'b0, dprod_s1[k]} + 57'h000_0000_0080_0000;
				a0 = vel_s1[k][31] ? $signed({4'b0, rs[55:24]}) : -$signed({4'b0, rs[55:24]});
				if (k == 2)
					a0 = a0 + $signed({14'b0, grav_q});
				acc_s2[k] <= sat32(a0);
				vel_s2[k] <= vel_s1[k];
			end
			dt_s2 <= dt_s1;
		end
	end

	// stage 3: |a| * dt
	logic [47:0] tprod_s3 [3];
	logic [31:0] acc_s3 [3];
	logic [31:0] vel_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				tprod_s3[k] <= 48'(mag32(acc_s2[k])) * 48'(dt_s2);
				acc_s3[k]   <= acc_s2[k];
				vel_s3[k]   <= vel_s2[k];
			end
		end
	end

	// stage 4: round step, add to velocity, saturate
	logic [31:0] nv_s4 [3];
	logic [31:0] acc_s4 [3];
	always_ff @(posedge clk) begin
		logic [48:0]        rs;
		logic signed [35:0] term;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rs   = {1'b0, tprod_s3[k]} + 49'h0_0000_0000_8000;
				term = acc_s3[k][31] ? -$signed({3'b0, rs[48:16]}) : $signed({3'b0, rs[48:16]});
				nv_s4[k]  <= sat32($signed({{4{vel_s3[k][31]}}, vel_s3[k]}) + term);
				acc_s4[k] <= acc_s3[k];
			end
		end
	end

	// stage 5: squares
	logic [63:0] sq_s5 [3];
	side_t       side_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				sq_s5[k] <= 64'(mag32(nv_s4[k])) * 64'(mag32(nv_s4[k]));
			side_s5 <= '{nv_n: nv_s4[0], nv_e: nv_s4[1], nv_d: nv_s4[2],
				ac_n: acc_s4[0], ac_e: acc_s4[1], ac_d: acc_s4[2]};
		end
	end

	// stage 6: horizontal and total sums of squares
	logic [63:0] hsq_s6;
	logic [63:0] tsq_s6;
	side_t       side_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			hsq_s6  <= sq_s5[0] + sq_s5[1];
			tsq_s6  <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			side_s6 <= side_s5;
		end
	end

	// square roots
	logic [31:0] gs_root;
	logic [31:0] ts_root;
	dgv_isqrt u_sqrt_ground (.clk(clk), .en(en), .radicand(hsq_s6), .root(gs_root));
	dgv_isqrt u_sqrt_total  (.clk(clk), .en(en), .radicand(tsq_s6), .root(ts_root));

	side_t side_sq [SQRT_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			side_sq[0] <= side_s6;
			for (int i = 1; i < SQRT_STEPS; i++)
				side_sq[i] <= side_sq[i-1];
		end
	end

	// angle units
	logic [15:0] pitch_raw;
	logic [15:0] head_raw;
	side_t       sd;
	assign sd = side_sq[SQRT_STEPS-1];

	dgv_cordic u_pitch (
		.clk  (clk),
		.en   (en),
		.x_in ($signed({1'b0, gs_root})),
		.y_in (-$signed({sd.nv_d[31], sd.nv_d})),
		.angle(pitch_raw)
	);

	dgv_cordic u_heading (
		.clk  (clk),
		.en   (en),
		.x_in ($signed({sd.nv_n[31], sd.nv_n})),
		.y_in ($signed({sd.nv_e[31], sd.nv_e})),
		.angle(head_raw)
	);

	spd_t spd_co [CORDIC_LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			spd_co[0] <= '{side: sd, total: ts_root, ground: gs_root};
			for (int i = 1; i < CORDIC_LAT; i++)
				spd_co[i] <= spd_co[i-1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			next_north    <= spd_co[CORDIC_LAT-1].side.nv_n;
			next_east     <= spd_co[CORDIC_LAT-1].side.nv_e;
			next_down     <= spd_co[CORDIC_LAT-1].side.nv_d;
			accel_north   <= spd_co[CORDIC_LAT-1].side.ac_n;
			accel_east    <= spd_co[CORDIC_LAT-1].side.ac_e;
			accel_down    <= spd_co[CORDIC_LAT-1].side.ac_d;
			total_speed   <= spd_co[CORDIC_LAT-1].total;
			ground_speed  <= spd_co[CORDIC_LAT-1].ground;
			pitch_angle   <= pitch_raw;
			heading_angle <= head_raw;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/dgv_checker.sv
// Port-level checks for the velocity step block, bound to the top level.
`default_nettype none
module dgv_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [31:0] next_north,
	input wire logic [31:0] total_speed,
	input wire logic [31:0] ground_speed,
	input wire logic        pready
);

	// a waiting beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// a waiting beat keeps its payload, checked on next_north and total_speed
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(next_north) && $stable(total_speed))
		else $error("result payload changed while stalled");

	// input backpressure comes only from a blocked output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("input stall does not match output state");

	// total speed includes the horizontal part
	a_speed_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> total_speed >= ground_speed)
		else $error("total speed below ground speed");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind drag_gravity_velocity_step dgv_props u_dgv_props (.*);
`default_nettype wire
